### hw/rtl/position_table_run_leb128_encoder_macros.svh
// Assertion helpers for the position table encoder.
`ifndef POSITION_TABLE_RUN_LEB128_ENCODER_MACROS_SVH
`define POSITION_TABLE_RUN_LEB128_ENCODER_MACROS_SVH

// Same-cycle implication.
`define PTRLE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptrle assertion failed");

// Next-cycle implication.
`define PTRLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptrle assertion failed");

`endif

### hw/rtl/ptrle_pkg.sv
`timescale 1ns / 1ps

package ptrle_pkg;

   localparam int POS_W   = 48;
   localparam int RUN_W   = 25;
   localparam int WORK_W  = POS_W + 1;
   localparam int GROUP_W = 7;
   localparam int BYTE_W  = 8;

   localparam logic [RUN_W-1:0] MAX_ENTRIES = RUN_W'(16777216);
   localparam logic [POS_W-1:0] NEG_SENTINEL = POS_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_VAL
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic signed_mode;
   } unit_ctrl_type;

   typedef struct packed {
      logic              done;
      logic [BYTE_W-1:0] group_byte;
   } unit_status_type;

endpackage

### hw/rtl/position_table_run_leb128_encoder.sv
// The request loads the group shifter; its first byte is registered onto rsp_ when the output slot is free.
// Throughput: one byte per cycle while rsp_ready holds; a new request is taken only once the
// item's last byte is registered, as the single 7-bit group shifter serves both the run and the value.
// A zero entry without end mark emits nothing and leaves the sequencer idle.
// Reset (synchronous): sequencer idle, no response pending, run count zero,
// remembered negative back to the positive sentinel.
`timescale 1ns / 1ps
`include "position_table_run_leb128_encoder_macros.svh"

module position_table_run_leb128_encoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [ptrle_pkg::POS_W-1:0]   req_position,
   input  logic                                 req_end_of_table,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ptrle_pkg::BYTE_W-1:0]         rsp_out_byte,
   output logic                                 rsp_last_of_item
);

   localparam int RUN_PAD = ptrle_pkg::WORK_W - ptrle_pkg::RUN_W - 1;

   ptrle_pkg::state_type              state_ff, state_in;
   logic [ptrle_pkg::RUN_W-1:0]       run_ff, run_in;
   logic [ptrle_pkg::POS_W-1:0]       last_neg_ff, last_neg_in;
   logic [ptrle_pkg::WORK_W-1:0]      val_ff, val_in;
   logic                              has_val_ff, has_val_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ptrle_pkg::BYTE_W-1:0]      rsp_byte_ff, rsp_byte_in;
   logic                              rsp_last_ff, rsp_last_in;

   ptrle_pkg::unit_ctrl_type          unit_ctrl;
   ptrle_pkg::unit_status_type        unit_status;
   logic [ptrle_pkg::WORK_W-1:0]      unit_value;

   logic                              req_fire;
   logic                              slot_free;
   logic                              pos_zero;
   logic                              neg_match;
   logic [ptrle_pkg::RUN_W-1:0]       run_inc;
   logic [ptrle_pkg::POS_W-1:0]       val_sel;
   logic [ptrle_pkg::WORK_W-1:0]      val_enc;

   assign req_ready        = (state_ff == ptrle_pkg::ST_IDLE);
   assign req_fire         = req_valid && req_ready;
   assign slot_free        = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_last_of_item = rsp_last_ff;

   assign pos_zero  = (req_position == '0);
   assign neg_match = (req_position == last_neg_ff);
   assign run_inc   = (run_ff < ptrle_pkg::MAX_ENTRIES) ? run_ff + 1'b1 : run_ff;
   assign val_sel   = (req_position[ptrle_pkg::POS_W-1] && neg_match) ? '0 : req_position;
   assign val_enc   = {val_sel, 1'b1};

   ptrle_group_unit u_group (
      .clock      (clock),
      .ctrl       (unit_ctrl),
      .load_value (unit_value),
      .status     (unit_status)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptrle_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (pos_zero) begin
                  state_in = req_end_of_table ? ptrle_pkg::ST_RUN : ptrle_pkg::ST_IDLE;
               end else begin
                  state_in = (run_ff != '0) ? ptrle_pkg::ST_RUN : ptrle_pkg::ST_VAL;
               end
            end
         end
         ptrle_pkg::ST_RUN: begin
            if (slot_free && unit_status.done) begin
               state_in = has_val_ff ? ptrle_pkg::ST_VAL : ptrle_pkg::ST_IDLE;
            end
         end
         ptrle_pkg::ST_VAL: begin
            if (slot_free && unit_status.done) begin
               state_in = ptrle_pkg::ST_IDLE;
            end
         end
         default: state_in = ptrle_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      run_in       = run_ff;
      last_neg_in  = last_neg_ff;
      val_in       = val_ff;
      has_val_in   = has_val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      unit_ctrl    = '0;
      unit_value   = val_ff;
      unique case (state_ff)
         ptrle_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (pos_zero) begin
                  run_in     = run_inc;
                  has_val_in = 1'b0;
                  unit_ctrl.load = req_end_of_table;
                  unit_value     = {{RUN_PAD{1'b0}}, run_inc, 1'b0};
               end else begin
                  val_in     = val_enc;
                  has_val_in = 1'b1;
                  run_in     = '0;
                  if (req_position[ptrle_pkg::POS_W-1] && !neg_match) begin
                     last_neg_in = req_position;
                  end
                  unit_ctrl.load = 1'b1;
                  if (run_ff != '0) begin
                     unit_value = {{RUN_PAD{1'b0}}, run_ff, 1'b0};
                  end else begin
                     unit_value            = val_enc;
                     unit_ctrl.signed_mode = 1'b1;
                  end
               end
               if (req_end_of_table) begin
                  run_in      = '0;
                  last_neg_in = ptrle_pkg::NEG_SENTINEL;
               end
            end
         end
         ptrle_pkg::ST_RUN, ptrle_pkg::ST_VAL: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_byte_in    = unit_status.group_byte;
               rsp_last_in    = unit_status.done &&
                                !(state_ff == ptrle_pkg::ST_RUN && has_val_ff);
               unit_ctrl.step = 1'b1;
               if (state_ff == ptrle_pkg::ST_RUN && unit_status.done && has_val_ff) begin
                  unit_ctrl.load        = 1'b1;
                  unit_ctrl.signed_mode = 1'b1;
                  unit_value            = val_ff;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptrle_pkg::ST_IDLE;
         run_ff       <= '0;
         last_neg_ff  <= ptrle_pkg::NEG_SENTINEL;
         has_val_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         last_neg_ff  <= last_neg_in;
         has_val_ff   <= has_val_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   `PTRLE_ASSERT_NOW(a_run_bounded, clock, reset, 1'b1, run_ff <= ptrle_pkg::MAX_ENTRIES)
   `PTRLE_ASSERT_NOW(a_last_byte_ends_number, clock, reset, rsp_valid_ff && rsp_last_ff, !rsp_byte_ff[ptrle_pkg::BYTE_W-1])
   `PTRLE_ASSERT_NEXT(a_quiet_zero, clock, reset, req_fire && pos_zero && !req_end_of_table, state_ff == ptrle_pkg::ST_IDLE)
   `PTRLE_ASSERT_NEXT(a_table_end_clears, clock, reset, req_fire && req_end_of_table, run_ff == '0 && last_neg_ff == ptrle_pkg::NEG_SENTINEL)

endmodule

### hw/rtl/ptrle_group_unit.sv
`timescale 1ns / 1ps

module ptrle_group_unit (
   input  logic                           clock,
   input  ptrle_pkg::unit_ctrl_type       ctrl,
   input  logic [ptrle_pkg::WORK_W-1:0]   load_value,
   output ptrle_pkg::unit_status_type     status
);

   logic [ptrle_pkg::WORK_W-1:0] work_ff;
   logic [ptrle_pkg::WORK_W-1:0] work_in;
   logic                         signed_ff;
   logic                         signed_in;
   logic [ptrle_pkg::WORK_W-1:0] rest;
   logic                         all_zero;
   logic                         all_one;
   logic                         sign_bit;

   assign rest     = ptrle_pkg::WORK_W'($signed(work_ff) >>> ptrle_pkg::GROUP_W);
   assign all_zero = (rest == '0);
   assign all_one  = (rest == '1);
   assign sign_bit = work_ff[ptrle_pkg::GROUP_W-1];

   always_comb begin
      work_in   = work_ff;
      signed_in = signed_ff;
      if (ctrl.load) begin
         work_in   = load_value;
         signed_in = ctrl.signed_mode;
      end else if (ctrl.step) begin
         work_in = rest;
      end
   end

   always_comb begin
      if (signed_ff) begin
         status.done = (all_zero && !sign_bit) || (all_one && sign_bit);
      end else begin
         status.done = all_zero;
      end
      status.group_byte = {!status.done, work_ff[ptrle_pkg::GROUP_W-1:0]};
   end

   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      signed_ff <= signed_in;
   end

endmodule
